[sv/wai_pkg.sv]
// ----------------------------------------------------------------------------
// wai_pkg - shared types and constants for the windowed alignment identity
// Widths, saturation limits and the sequencer state type used by the block.
// ----------------------------------------------------------------------------
package wai_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int WS_W       = 11;
    localparam int CNT_W      = 11;
    localparam int TOT_W      = 20;
    localparam int ID_W       = 14;
    localparam int CHAR_W     = 8;

    localparam logic [TOT_W-1:0] LENGTH_MAX = TOT_W'(1048575);
    localparam logic [TOT_W-1:0] TOTAL_SAT  = TOT_W'(1048575);
    localparam logic [CNT_W-1:0] COUNT_SAT  = CNT_W'(2047);
    localparam logic [ID_W-1:0]  SCALE      = ID_W'(10000);

    // Divider operands: numerator is a count times the scale, the divisor
    // is a column count or a window size.
    localparam int NUM_W     = TOT_W + ID_W;
    localparam int DEN_W     = TOT_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = 2 * CHAR_W;
    localparam int M_TDATA_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DONE
    } t_state;

endpackage

[sv/windowed_alignment_identity.sv]
// ----------------------------------------------------------------------------
// windowed_alignment_identity - sliding window mismatch identity
// Counts differing columns of an alignment over a sliding window and in total,
// and on the final column reports global and worst-window identity.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid/tready           tdata: query, target; tlast: last
// m_axis    out        tvalid/tready           tdata: identities, counts; tuser
// cfg       in         i_cfg_we (no wait)      i_cfg_wdata: window size
//
// An ordinary column is accepted in the idle state, which reads the history
// bit that leaves the window, then goes through the update state, which
// updates the counters and writes the new bit. The final column adds two
// divisions on one shared restoring divider, each a load state and 34 one-bit
// steps, and a done state that hands the result to the output register.
// Reset is synchronous and active low; the history memory is not cleared.
// A result waiting in the output register does not stop new columns from
// being taken; only a second result waits until the first beat has gone.
// ----------------------------------------------------------------------------
module windowed_alignment_identity
    import wai_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: window size in columns.
    input  logic                 i_cfg_we,
    input  logic [WS_W-1:0]      i_cfg_wdata,
    // Column input.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] query_char, [15:8] target_char
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    // Result output.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [13:0] global_identity, [27:14] worst_window_identity,
    // [47:28] mismatch_total, [58:48] worst_window_mismatches, [63:59] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] window_too_long
    output logic                 m_axis_tuser
);

    // Control and counter state.
    t_state             r_state,    n_state;
    logic [WS_W-1:0]    r_cfg_ws;
    logic [PTR_W-1:0]   r_wp,       n_wp;
    logic [CNT_W-1:0]   r_win_cnt,  n_win_cnt;
    logic [CNT_W-1:0]   r_worst,    n_worst;
    logic [TOT_W-1:0]   r_tot,      n_tot;
    logic [TOT_W-1:0]   r_col_cnt,  n_col_cnt;
    logic               r_div_sel,  n_div_sel;
    logic [DCNT_W-1:0]  r_div_cnt,  n_div_cnt;
    logic               r_m_valid,  n_m_valid;

    // Payload registers.
    logic               r_m,        n_m;
    logic               r_last,     n_last;
    logic               r_rd_bit;
    logic [NUM_W-1:0]   r_num,      n_num;
    logic [DEN_W-1:0]   r_den,      n_den;
    logic [DEN_W-1:0]   r_rem,      n_rem;
    logic [ID_W-1:0]    r_id_glob,  n_id_glob;
    logic [M_TDATA_W-1:0] r_m_data, n_m_data;
    logic               r_m_user,   n_m_user;

    // Mismatch history ring.
    logic               r_hist [WINDOW_MAX];

    logic [WS_W-1:0]    ws;
    logic [PTR_W-1:0]   rd_idx;
    logic               s_acc;
    logic               full_win;
    logic               dec;
    logic [CNT_W-1:0]   wc_dec;
    logic [DEN_W:0]     rem_sh;
    logic               q_bit;
    logic [ID_W-1:0]    id_val;
    logic               short_aln;

    // Out-of-range window sizes are pinned to the nearest legal value.
    always_comb begin
        if (r_cfg_ws == '0) begin
            ws = WS_W'(1);
        end else if (r_cfg_ws > WS_W'(WINDOW_MAX)) begin
            ws = WS_W'(WINDOW_MAX);
        end else begin
            ws = r_cfg_ws;
        end
    end

    // The bit leaving the window sits ws places behind the write pointer.
    // With the full ring as window this is the entry about to be overwritten.
    assign rd_idx = r_wp - ws[PTR_W-1:0];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign full_win  = (r_col_cnt >= TOT_W'(ws));
    assign dec       = full_win && r_rd_bit && (r_win_cnt != '0);
    assign wc_dec    = r_win_cnt - CNT_W'(dec);

    // One restoring division step: one compare and subtract per cycle.
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    // The quotient is clamped to the scale before it is turned into identity.
    assign id_val = (r_num > NUM_W'(SCALE)) ? '0 : (SCALE - r_num[ID_W-1:0]);

    assign short_aln = (r_col_cnt < TOT_W'(ws));

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_win_cnt = r_win_cnt;
        n_worst   = r_worst;
        n_tot     = r_tot;
        n_col_cnt = r_col_cnt;
        n_div_sel = r_div_sel;
        n_div_cnt = r_div_cnt;
        n_m_valid = r_m_valid;
        n_m       = r_m;
        n_last    = r_last;
        n_num     = r_num;
        n_den     = r_den;
        n_rem     = r_rem;
        n_id_glob = r_id_glob;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_m     = (s_axis_tdata[CHAR_W-1:0] != s_axis_tdata[2*CHAR_W-1:CHAR_W]);
                    n_last  = s_axis_tlast;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_wp      = r_wp + PTR_W'(1);
                n_win_cnt = (r_m && wc_dec != COUNT_SAT) ? wc_dec + CNT_W'(1) : wc_dec;
                n_tot     = (r_m && r_tot != TOTAL_SAT) ? r_tot + TOT_W'(1) : r_tot;
                n_col_cnt = (r_col_cnt < LENGTH_MAX) ? r_col_cnt + TOT_W'(1) : r_col_cnt;
                if (n_col_cnt >= TOT_W'(ws) && n_win_cnt > r_worst) begin
                    n_worst = n_win_cnt;
                end
                n_div_sel = 1'b0;
                n_state   = r_last ? ST_DIV_LOAD : ST_IDLE;
            end
            ST_DIV_LOAD: begin
                if (!r_div_sel) begin
                    n_num = NUM_W'(r_tot) * NUM_W'(SCALE);
                    n_den = (r_col_cnt == '0) ? DEN_W'(1) : r_col_cnt;
                end else begin
                    n_num = NUM_W'(r_worst) * NUM_W'(SCALE);
                    n_den = DEN_W'(ws);
                end
                n_rem     = '0;
                n_div_cnt = '0;
                n_state   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                n_rem     = q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
                n_num     = {r_num[NUM_W-2:0], q_bit};
                n_div_cnt = r_div_cnt + DCNT_W'(1);
                if (r_div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DIV_LOAD;
                    n_div_sel = 1'b1;
                    if (r_div_sel) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // The global identity was captured as the first division
                // ended; the local one comes straight from the quotient.
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = '0;
                    n_m_data[ID_W-1:0]       = r_id_glob;
                    n_m_data[2*ID_W-1:ID_W]  = short_aln ? '0 : id_val;
                    n_m_data[2*ID_W+TOT_W-1:2*ID_W] = r_tot;
                    n_m_data[2*ID_W+TOT_W+CNT_W-1:2*ID_W+TOT_W] =
                        short_aln ? '0 : r_worst;
                    n_m_user  = short_aln;
                    // Start the next alignment from a clean slate.
                    n_wp      = '0;
                    n_win_cnt = '0;
                    n_worst   = '0;
                    n_tot     = '0;
                    n_col_cnt = '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Capture the global identity as the first division finishes.
        if (r_state == ST_DIV_RUN && !r_div_sel
            && r_div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
            n_id_glob = (n_num > NUM_W'(SCALE)) ? '0 : (SCALE - n_num[ID_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg_ws  <= WS_W'(100);
            r_wp      <= '0;
            r_win_cnt <= '0;
            r_worst   <= '0;
            r_tot     <= '0;
            r_col_cnt <= '0;
            r_div_sel <= 1'b0;
            r_div_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_cfg_ws <= i_cfg_wdata;
            end
            r_wp      <= n_wp;
            r_win_cnt <= n_win_cnt;
            r_worst   <= n_worst;
            r_tot     <= n_tot;
            r_col_cnt <= n_col_cnt;
            r_div_sel <= n_div_sel;
            r_div_cnt <= n_div_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_last    <= n_last;
        r_num     <= n_num;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_id_glob <= n_id_glob;
        r_m_data  <= n_m_data;
        r_m_user  <= n_m_user;
    end

    // History ring: read on acceptance, written in the update cycle.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_rd_bit <= r_hist[rd_idx];
        end
        if (r_state == ST_UPDATE) begin
            r_hist[r_wp] <= r_m;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // An accepted column is always followed by its update cycle.
    a_acc_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_UPDATE))
        else $error("accepted column not followed by update");

    // A new result appears only from the final hand-over state.
    a_rise_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside hand-over");

    // Reported identities never exceed the full scale.
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ID_W-1:0] <= SCALE
                           && m_axis_tdata[2*ID_W-1:ID_W] <= SCALE))
        else $error("identity above full scale");

    // An alignment that reaches the divider has at least one column.
    a_cols_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_LOAD) |-> (r_col_cnt != '0))
        else $error("division started with no columns");

    // Mismatch totals never exceed the column count.
    a_tot_le_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tot <= r_col_cnt))
        else $error("mismatch total above column count");

endmodule

[test/windowed_alignment_identity_tb.sv]
// ----------------------------------------------------------------------------
// windowed_alignment_identity_tb - self-checking bench for the identity block
// Streams aligned columns into the block and predicts every report in step.
// Each report beat is compared field by field with the prediction. The run
// covers directed edge cases, window size changes within an alignment, and
// randomised alignments under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module windowed_alignment_identity_tb;
    import wai_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass after the last report before the block counts as idle.
    localparam int DRAIN_CYCLES = 100;

    // One expected report beat, held as separate fields.
    typedef struct {
        logic [ID_W-1:0]  glob_id;
        logic [ID_W-1:0]  win_id;
        logic [TOT_W-1:0] mism_total;
        logic [CNT_W-1:0] worst_mism;
        logic             too_long;
    } t_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [WS_W-1:0]      i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // Predictor state: our own picture of the block's counters and history.
    logic        hist_bits [WINDOW_MAX];
    int unsigned wr_ptr;
    int unsigned win_cnt;
    int unsigned worst_cnt;
    int unsigned mism_cnt;
    int unsigned col_cnt;
    logic [WS_W-1:0] win_size_reg;

    t_report expected_reports[$];
    t_report seen_report;

    int failures = 0;
    int columns_sent = 0;
    int alignments_sent = 0;
    int reports_checked = 0;
    int sender_idle_pct = 0;
    int sink_stall_pct = 0;

    windowed_alignment_identity uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock, starting low so that the first edge is a rising one.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver decides afresh on every falling edge whether to stall.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // A window size of zero behaves as one, anything past the ring depth
    // behaves as the full ring.
    function automatic int unsigned eff_window(input logic [WS_W-1:0] ws);
        if (ws == '0) begin
            return 1;
        end
        if (ws > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return int'(ws);
    endfunction

    // Identity in hundredths of a percent. The ratio is truncated and held
    // at the scale, so a window count above the window size gives zero.
    function automatic logic [ID_W-1:0] identity_hundredths(input longint unsigned bad,
                                                           input longint unsigned cols);
        longint unsigned ratio;
        ratio = (bad * SCALE) / cols;
        if (ratio > SCALE) begin
            ratio = SCALE;
        end
        return ID_W'(SCALE - ratio);
    endfunction

    function automatic void clear_alignment_state();
        wr_ptr    = 0;
        win_cnt   = 0;
        worst_cnt = 0;
        mism_cnt  = 0;
        col_cnt   = 0;
    endfunction

    // Advances the predicted counters by one accepted column and, on the
    // final column of an alignment, queues the report it must produce.
    function automatic void account_column(input logic [CHAR_W-1:0] q,
                                           input logic [CHAR_W-1:0] t,
                                           input logic last);
        int unsigned ws;
        int unsigned drop_idx;
        logic        miss;
        t_report     rep;
        logic        short_aln;
        ws   = eff_window(win_size_reg);
        miss = (q != t);
        // The bit leaving the window is only there once a full window exists.
        if (col_cnt >= ws) begin
            drop_idx = (wr_ptr + WINDOW_MAX - ws) % WINDOW_MAX;
            if (hist_bits[drop_idx] && win_cnt > 0) begin
                win_cnt--;
            end
        end
        hist_bits[wr_ptr] = miss;
        wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
        if (miss && win_cnt < COUNT_SAT) begin
            win_cnt++;
        end
        if (miss && mism_cnt < TOTAL_SAT) begin
            mism_cnt++;
        end
        if (col_cnt < LENGTH_MAX) begin
            col_cnt++;
        end
        if (col_cnt >= ws && win_cnt > worst_cnt) begin
            worst_cnt = win_cnt;
        end
        if (last) begin
            short_aln      = (col_cnt < ws);
            rep.glob_id    = identity_hundredths(mism_cnt, (col_cnt == 0) ? 1 : col_cnt);
            rep.win_id     = short_aln ? '0 : identity_hundredths(worst_cnt, ws);
            rep.mism_total = TOT_W'(mism_cnt);
            rep.worst_mism = short_aln ? '0 : CNT_W'(worst_cnt);
            rep.too_long   = short_aln;
            expected_reports.insert(expected_reports.size(), rep);
            clear_alignment_state();
            alignments_sent++;
        end
    endfunction

    // Every report beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                $error("report beat arrived with no report expected");
                failures++;
            end else begin
                seen_report = expected_reports.pop_front();
                reports_checked++;
                if (m_axis_tdata[ID_W-1:0] !== seen_report.glob_id) begin
                    $error("global_identity: expected %0d, got %0d",
                           seen_report.glob_id, m_axis_tdata[ID_W-1:0]);
                    failures++;
                end
                if (m_axis_tdata[2*ID_W-1:ID_W] !== seen_report.win_id) begin
                    $error("worst_window_identity: expected %0d, got %0d",
                           seen_report.win_id, m_axis_tdata[2*ID_W-1:ID_W]);
                    failures++;
                end
                if (m_axis_tdata[2*ID_W+TOT_W-1:2*ID_W] !== seen_report.mism_total) begin
                    $error("mismatch_total: expected %0d, got %0d",
                           seen_report.mism_total, m_axis_tdata[2*ID_W+TOT_W-1:2*ID_W]);
                    failures++;
                end
                if (m_axis_tdata[2*ID_W+TOT_W+CNT_W-1:2*ID_W+TOT_W]
                        !== seen_report.worst_mism) begin
                    $error("worst_window_mismatches: expected %0d, got %0d",
                           seen_report.worst_mism,
                           m_axis_tdata[2*ID_W+TOT_W+CNT_W-1:2*ID_W+TOT_W]);
                    failures++;
                end
                if (m_axis_tuser !== seen_report.too_long) begin
                    $error("window_too_long: expected %0d, got %0d",
                           seen_report.too_long, m_axis_tuser);
                    failures++;
                end
            end
        end
    end

    // Offers one column and returns at the rising edge that accepts it.
    // Each call starts on a falling edge, where tvalid is either kept up
    // for the new beat or dropped for an idle gap, never both.
    task automatic send_column(input logic [CHAR_W-1:0] q,
                               input logic [CHAR_W-1:0] t,
                               input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, q};
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        account_column(q, t, last);
        columns_sent++;
    endtask

    // Stops offering columns, waits for every predicted report to arrive,
    // then gives the block time to finish any column still in hand.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Window size writes happen only once the block has gone quiet.
    task automatic write_window(input logic [WS_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        win_size_reg = value;
    endtask

    // A random column: matching characters or a differing pair.
    task automatic send_random_column(input int mism_pct, input logic last);
        logic [CHAR_W-1:0] q;
        logic [CHAR_W-1:0] t;
        q = CHAR_W'($urandom);
        t = q;
        if ($urandom_range(99) < mism_pct) begin
            t = q ^ CHAR_W'($urandom_range(1, 255));
        end
        send_column(q, t, last);
    endtask

    // A whole alignment of random columns. A non-negative resize_at changes
    // the window size just before that column, with the alignment open.
    task automatic send_alignment(input int len, input int mism_pct,
                                  input int resize_at, input logic [WS_W-1:0] resize_val);
        for (int i = 0; i < len; i++) begin
            if (i == resize_at) begin
                write_window(resize_val);
            end
            send_random_column(mism_pct, i == len - 1);
        end
    endtask

    // The reset window of 100 is far longer than this alignment, so the
    // report must flag it and leave the local figures at zero.
    task automatic test_reset_window();
        send_column(8'h00, 8'h00, 1'b0);
        send_column(8'hFF, 8'h00, 1'b0);
        send_column(8'hFF, 8'hFF, 1'b1);
    endtask

    // Window sizes at and beyond both ends of the legal range.
    task automatic test_window_extremes();
        write_window(WS_W'(0));
        send_column(8'h00, 8'hFF, 1'b1);
        send_column(8'h12, 8'h12, 1'b0);
        send_column(8'hAA, 8'h55, 1'b0);
        send_column(8'h7F, 8'h80, 1'b1);
        write_window(WS_W'(1));
        send_column(8'h01, 8'h01, 1'b1);
        write_window(WS_W'(WINDOW_MAX));
        send_column(8'hC3, 8'h3C, 1'b0);
        send_column(8'h5A, 8'h5A, 1'b1);
        write_window(WS_W'(WINDOW_MAX + 1));
        send_column(8'hF0, 8'h0F, 1'b1);
        write_window(WS_W'(2047));
        send_column(8'h80, 8'h80, 1'b1);
    endtask

    // Shrinking the window mid-alignment leaves the worst count above the
    // new size, which drives the ratio past the scale and the local
    // identity down to zero. Growing it afterwards makes the alignment
    // too short for the new window.
    task automatic test_mid_alignment_resize();
        write_window(WS_W'(4));
        repeat (5) send_column(8'hFF, 8'h00, 1'b0);
        write_window(WS_W'(1));
        send_column(8'h00, 8'hFF, 1'b1);
        write_window(WS_W'(2));
        send_column(8'h11, 8'h22, 1'b0);
        send_column(8'h33, 8'h33, 1'b0);
        send_column(8'h44, 8'h55, 1'b0);
        write_window(WS_W'(8));
        send_column(8'h66, 8'h66, 1'b0);
        send_column(8'h77, 8'h78, 1'b0);
        send_column(8'h99, 8'h99, 1'b1);
    endtask

    // A run of random alignments under the current idling pattern. Most
    // use small windows and lengths around them so that full windows occur;
    // a few use the largest sizes with short alignments.
    task automatic test_random_phase(input int src_idle, input int snk_stall,
                                     input int col_budget);
        int          start_cols;
        int          len;
        int          pct;
        int          resize_at;
        int unsigned ws;
        int          pick;
        logic [WS_W-1:0] new_ws;
        wait_idle();
        sender_idle_pct = src_idle;
        sink_stall_pct  = snk_stall;
        start_cols      = columns_sent;
        while (columns_sent - start_cols < col_budget) begin
            if ($urandom_range(99) < 40) begin
                pick = $urandom_range(9);
                if (pick < 7) begin
                    new_ws = WS_W'($urandom_range(1, 16));
                end else if (pick == 7) begin
                    new_ws = WS_W'(0);
                end else if (pick == 8) begin
                    new_ws = WS_W'($urandom_range(17, 64));
                end else begin
                    new_ws = WS_W'($urandom_range(WINDOW_MAX, 2047));
                end
                write_window(new_ws);
            end
            ws = eff_window(win_size_reg);
            if (ws > 64) begin
                len = $urandom_range(1, 20);
            end else if ($urandom_range(3) != 0) begin
                len = $urandom_range(ws, ws + 24);
            end else begin
                len = $urandom_range(1, ws + 24);
            end
            case ($urandom_range(3))
                0: pct = 0;
                1: pct = 100;
                default: pct = $urandom_range(1, 99);
            endcase
            resize_at = -1;
            if (len > 2 && $urandom_range(7) == 0) begin
                resize_at = $urandom_range(1, len - 1);
            end
            send_alignment(len, pct, resize_at, WS_W'($urandom_range(1, 16)));
        end
    endtask

    initial begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            hist_bits[i] = 1'b0;
        end
        clear_alignment_state();
        win_size_reg = WS_W'(100);

        // Reset is held low from the start and released on a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_window_extremes();
        test_mid_alignment_resize();
        test_random_phase(0, 0, 140);
        test_random_phase(70, 0, 140);
        test_random_phase(0, 70, 140);
        test_random_phase(35, 35, 140);
        wait_idle();

        $display("Checked %0d reports from %0d alignments (%0d columns).",
                 reports_checked, alignments_sent, columns_sent);
        $display("Window sizes 0 to 2047, resizes within alignments, four idling patterns.");
        if (failures == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/wai_pkg.sv
sv/windowed_alignment_identity.sv
test/windowed_alignment_identity_tb.sv
